>>> rtl/dmwc_pkg.sv
// shared constants, types and state encoding of the direct-mapped write-back cache
package dmwc_pkg;

  localparam int unsigned ADDR_W       = 20;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned OFFS_W       = 4;
  localparam int unsigned BLK_W        = ADDR_W - OFFS_W;
  localparam int unsigned BLOCK_BYTES  = 16;
  localparam int unsigned ACCESS_BYTES = 4;
  localparam int unsigned LINE_W       = 8 * BLOCK_BYTES;

  localparam int unsigned LINES        = 16;
  localparam int unsigned IDX_W        = $clog2(LINES);
  localparam int unsigned TAG_W        = BLK_W - IDX_W;

  localparam int unsigned MEM_BLOCKS   = 65536;
  localparam int unsigned MEM_AW       = $clog2(MEM_BLOCKS);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_REFILL
  } state_e;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [LINE_W-1:0] block;
  } line_t;

endpackage

>>> rtl/dmwc_if.sv
// request and response channel interfaces of the cache
interface dmwc_req_if import dmwc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output op, output address, output write_data, input ready);
  modport sink   (input valid, input op, input address, input write_data, output ready);
endinterface

interface dmwc_rsp_if import dmwc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DATA_W-1:0] read_data;
  logic              wrote_back;

  modport source (output valid, output hit, output read_data, output wrote_back, input ready);
  modport sink   (input valid, input hit, input read_data, input wrote_back, output ready);
endinterface

>>> rtl/dmwc_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module dmwc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/direct_mapped_writeback_cache.sv
// top level of the direct-mapped write-back write-allocate cache
//
// requests arrive on req_i (op, address, write_data) and results leave on
// rsp_o (hit, read_data, wrote_back), both valid/ready channels; a transfer
// happens on a clock edge with valid and ready high.
// the address splits into tag, line index and byte offset; four bytes are
// read or written at the offset, bytes past the block end read as zero.
// line tags and data sit in a small ram, valid and dirty bits in flops, and
// the block memory behind it is a single-port-write ram.
// one request is in flight at a time: a hit loads the result register from
// the lookup step, a miss from the refill step (victim writeback and refill
// read share the block memory in lookup, then the line is rewritten).
// a new request is taken while an earlier result still waits on rsp_o; the
// pipeline holds in the lookup or refill step while rsp_o is stalled.
// after reset the block memory is zeroed one block per cycle, all 65536
// blocks, with req_i.ready low; line valid and dirty bits clear at once.
module direct_mapped_writeback_cache import dmwc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  dmwc_req_if.sink       req_i,
  dmwc_rsp_if.source     rsp_o
);

  state_e state_q, state_d;

  logic              op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;
  logic [LINES-1:0]  valid_q;
  logic [LINES-1:0]  dirty_q;
  logic [MEM_AW-1:0] clr_q;
  logic              wb_q;
  logic              refill_ok_q;

  logic              rsp_valid_q;
  logic              hit_q;
  logic [DATA_W-1:0] rdata_q;
  logic              wrote_back_q;

  logic [IDX_W-1:0]  idx_q;
  logic [TAG_W-1:0]  tag_q;
  logic [OFFS_W-1:0] offs_q;
  logic [BLK_W-1:0]  blk_q;
  logic [BLK_W-1:0]  victim_blk;

  line_t             line_rdata;
  line_t             line_wdata;
  logic              line_re;
  logic              line_we;
  logic [LINE_W-1:0] mem_rdata;
  logic [LINE_W-1:0] base_block;
  logic [LINE_W-1:0] new_block;

  logic              mem_we;
  logic              mem_re;
  logic [MEM_AW-1:0] mem_waddr;
  logic [LINE_W-1:0] mem_wdata;

  logic              in_ready;
  logic              out_free;
  logic              lookup_hit;
  logic              victim_dirty;
  logic              victim_ok;
  logic              refill_ok;
  logic              load_out;
  logic              out_hit;
  logic              out_wb;
  logic              dirty_d;

  function automatic logic [LINE_W-1:0] merge_bytes(logic [LINE_W-1:0] blk,
                                                   logic [OFFS_W-1:0] offs,
                                                   logic [DATA_W-1:0] wd);
    logic [LINE_W-1:0] res;
    logic [OFFS_W:0]   p;
    res = blk;
    for (int i = 0; i < ACCESS_BYTES; i++) begin
      p = {1'b0, offs} + (OFFS_W+1)'(i);
      if (p < (OFFS_W+1)'(BLOCK_BYTES)) begin
        res[LINE_W-1-8*p[OFFS_W-1:0] -: 8] = wd[DATA_W-1-8*i -: 8];
      end
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] pick_bytes(logic [LINE_W-1:0] blk,
                                                  logic [OFFS_W-1:0] offs);
    logic [DATA_W-1:0] res;
    logic [OFFS_W:0]   p;
    res = '0;
    for (int i = 0; i < ACCESS_BYTES; i++) begin
      p = {1'b0, offs} + (OFFS_W+1)'(i);
      if (p < (OFFS_W+1)'(BLOCK_BYTES)) begin
        res[DATA_W-1-8*i -: 8] = blk[LINE_W-1-8*p[OFFS_W-1:0] -: 8];
      end
    end
    return res;
  endfunction

  assign offs_q = addr_q[OFFS_W-1:0];
  assign blk_q  = addr_q[ADDR_W-1:OFFS_W];
  assign idx_q  = blk_q[IDX_W-1:0];
  assign tag_q  = blk_q[BLK_W-1:IDX_W];

  assign victim_blk   = {line_rdata.tag, idx_q};
  assign lookup_hit   = valid_q[idx_q] && (line_rdata.tag == tag_q);
  assign victim_dirty = valid_q[idx_q] && dirty_q[idx_q];
  assign victim_ok    = {1'b0, victim_blk} < (BLK_W+1)'(MEM_BLOCKS);
  assign refill_ok    = {1'b0, blk_q} < (BLK_W+1)'(MEM_BLOCKS);
  assign out_free     = !rsp_valid_q || rsp_o.ready;

  // line ram and block memory
  dmwc_ram #(
    .Width ($bits(line_t)),
    .Depth (LINES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (idx_q),
    .wdata_i (line_wdata),
    .re_i    (line_re),
    .raddr_i (req_i.address[OFFS_W+IDX_W-1:OFFS_W]),
    .rdata_o (line_rdata)
  );

  dmwc_ram #(
    .Width (LINE_W),
    .Depth (MEM_BLOCKS)
  ) u_mem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (blk_q[MEM_AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == MEM_AW'(MEM_BLOCKS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_i.valid) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!lookup_hit) begin
          state_d = ST_REFILL;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_REFILL: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    line_re    = 1'b0;
    line_we    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = clr_q;
    mem_wdata  = '0;
    load_out   = 1'b0;
    out_hit    = 1'b0;
    out_wb     = 1'b0;
    dirty_d    = 1'b0;
    base_block = line_rdata.block;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        line_re  = req_i.valid;
      end
      ST_LOOKUP: begin
        if (lookup_hit) begin
          if (out_free) begin
            line_we  = 1'b1;
            load_out = 1'b1;
            out_hit  = 1'b1;
            dirty_d  = dirty_q[idx_q] || (op_q == OP_WRITE);
          end
        end else begin
          mem_re    = 1'b1;
          mem_we    = victim_dirty && victim_ok;
          mem_waddr = victim_blk[MEM_AW-1:0];
          mem_wdata = line_rdata.block;
        end
      end
      ST_REFILL: begin
        base_block = refill_ok_q ? mem_rdata : '0;
        if (out_free) begin
          line_we  = 1'b1;
          load_out = 1'b1;
          out_wb   = wb_q;
          dirty_d  = (op_q == OP_WRITE);
        end
      end
      default: ;
    endcase
  end

  assign new_block        = (op_q == OP_WRITE) ? merge_bytes(base_block, offs_q, wdata_q)
                                               : base_block;
  assign line_wdata.tag   = tag_q;
  assign line_wdata.block = new_block;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      valid_q     <= '0;
      dirty_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + MEM_AW'(1);
      if (line_we) begin
        valid_q[idx_q] <= 1'b1;
        dirty_q[idx_q] <= dirty_d;
      end
      if (load_out) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      op_q    <= req_i.op;
      addr_q  <= req_i.address;
      wdata_q <= req_i.write_data;
    end
    if (state_q == ST_LOOKUP && !lookup_hit) begin
      wb_q        <= victim_dirty;
      refill_ok_q <= refill_ok;
    end
    if (load_out) begin
      hit_q        <= out_hit;
      rdata_q      <= pick_bytes(new_block, offs_q);
      wrote_back_q <= out_wb;
    end
  end

  assign req_i.ready      = in_ready;
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit        = hit_q;
  assign rsp_o.read_data  = rdata_q;
  assign rsp_o.wrote_back = wrote_back_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!rsp_valid_q || rsp_o.ready))
    else $error("result register overwritten while holding an untaken result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != blk_q[MEM_AW-1:0]))
    else $error("victim writeback aimed at the refill block");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP && !lookup_hit) |=> (state_q == ST_REFILL))
    else $error("miss did not go to refill");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_we |=> valid_q[$past(idx_q)])
    else $error("line written but not marked valid");

endmodule

>>> bench/direct_mapped_writeback_cache_tb.sv
// self-checking testbench of the direct-mapped write-back cache with a line and memory predictor
module direct_mapped_writeback_cache_tb import dmwc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // clearing pass after reset plus generous margin
  localparam int unsigned STALL_LIMIT = 4 * MEM_BLOCKS + 2000;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned TAG_POOL = 4;

  class cache_scoreboard;
    typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_data;
      logic              wrote_back;
    } result_t;

    bit                line_valid[LINES];
    bit                line_dirty[LINES];
    logic [TAG_W-1:0]  line_tag[LINES];
    logic [LINE_W-1:0] line_data[LINES];
    logic [LINE_W-1:0] memory[int unsigned];
    result_t           awaited[$];
    int unsigned       errors;

    function new();
      foreach (line_tag[i]) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_tag[i]   = '0;
        line_data[i]  = '0;
      end
      errors = 0;
    endfunction

    function logic [LINE_W-1:0] fetch_block(int unsigned blk);
      if (blk < MEM_BLOCKS && memory.exists(blk)) return memory[blk];
      return '0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      errors++;
    endtask

    task note_request(op_e op, logic [ADDR_W-1:0] address, logic [DATA_W-1:0] wdata);
      int unsigned      blk;
      int unsigned      offs;
      int unsigned      idx;
      int unsigned      victim;
      int unsigned      p;
      logic [TAG_W-1:0] tg;
      result_t          r;
      blk  = address >> OFFS_W;
      offs = address % BLOCK_BYTES;
      idx  = blk % LINES;
      tg   = TAG_W'(blk / LINES);
      r    = '0;
      if (line_valid[idx] && line_tag[idx] == tg) begin
        r.hit = 1'b1;
      end else begin
        if (line_valid[idx] && line_dirty[idx]) begin
          victim = line_tag[idx] * LINES + idx;
          if (victim < MEM_BLOCKS) memory[victim] = line_data[idx];
          r.wrote_back = 1'b1;
        end
        line_data[idx]  = fetch_block(blk);
        line_valid[idx] = 1'b1;
        line_dirty[idx] = 1'b0;
        line_tag[idx]   = tg;
      end
      if (op == OP_WRITE) begin
        for (int i = 0; i < ACCESS_BYTES; i++) begin
          p = offs + i;
          if (p < BLOCK_BYTES)
            line_data[idx][LINE_W-1-8*p -: 8] = wdata[DATA_W-1-8*i -: 8];
        end
        line_dirty[idx] = 1'b1;
      end
      for (int i = 0; i < ACCESS_BYTES; i++) begin
        p = offs + i;
        if (p < BLOCK_BYTES)
          r.read_data[DATA_W-1-8*i -: 8] = line_data[idx][LINE_W-1-8*p -: 8];
      end
      awaited = {awaited, r};
    endtask

    task check_response(logic hit, logic [DATA_W-1:0] rdata, logic wb);
      result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected response read_data", rdata, '0);
      end else begin
        want = awaited.pop_front();
        if (hit !== want.hit) report_mismatch("hit", DATA_W'(hit), DATA_W'(want.hit));
        if (rdata !== want.read_data) report_mismatch("read_data", rdata, want.read_data);
        if (wb !== want.wrote_back)
          report_mismatch("wrote_back", DATA_W'(wb), DATA_W'(want.wrote_back));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  dmwc_req_if req_if ();
  dmwc_rsp_if rsp_if ();

  direct_mapped_writeback_cache uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  cache_scoreboard  sb;
  bit               gaps_on;
  bit               rsp_stalls;
  int unsigned      idle_cycles;
  logic [TAG_W-1:0] tag_pool[TAG_POOL];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_request(op_e op, logic [ADDR_W-1:0] address, logic [DATA_W-1:0] wdata);
    @(negedge clk_i);
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.address    <= address;
    req_if.write_data <= wdata;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic idle_request(int unsigned cycles);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic drain_responses();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic send_random();
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] wdata;
    op_e               op;
    address = ADDR_W'($urandom);
    if ($urandom_range(0, 99) < 85)
      address[ADDR_W-1 -: TAG_W] = tag_pool[$urandom_range(0, TAG_POOL - 1)];
    op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
    case ($urandom_range(0, 19))
      0:       wdata = '0;
      1:       wdata = '1;
      default: wdata = $urandom;
    endcase
    send_request(op, address, wdata);
  endtask

  // transfer monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        sb.check_response(rsp_if.hit, rsp_if.read_data, rsp_if.wrote_back);
      if (req_if.valid && req_if.ready)
        sb.note_request(op_e'(req_if.op), req_if.address, req_if.write_data);
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned len;
    forever begin
      @(negedge clk_i);
      if (!rsp_stalls || $urandom_range(0, 2) != 0) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b0;
        len = gap_length();
        repeat (len - 1) @(negedge clk_i);
      end
    end
  end

  initial begin
    sb                = new();
    idle_cycles       = 0;
    gaps_on           = 1'b0;
    rsp_stalls        = 1'b0;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.op         = OP_READ;
    req_if.address    = '0;
    req_if.write_data = '0;
    rsp_if.ready      = 1'b0;
    foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // invalid line with matching zero tag, then hits
    send_request(OP_READ,  20'h00000, 32'h0000_0000);
    send_request(OP_WRITE, 20'h00000, 32'hDEAD_BEEF);
    send_request(OP_READ,  20'h00000, 32'h0000_0000);
    // bytes past the block end
    send_request(OP_WRITE, 20'h0000F, 32'hA1B2_C3D4);
    send_request(OP_READ,  20'h0000D, 32'h0000_0000);
    // dirty victim written back, then clean victim replaced
    send_request(OP_READ,  20'h00100, 32'h0000_0000);
    send_request(OP_READ,  20'h00000, 32'h0000_0000);
    send_request(OP_READ,  20'h0000E, 32'h0000_0000);
    // top of the address space
    send_request(OP_WRITE, 20'hFFFFF, 32'hFFFF_FFFF);
    send_request(OP_WRITE, 20'hFFFF0, 32'hFFFF_FFFF);
    send_request(OP_READ,  20'hFFFFC, 32'h0000_0000);
    send_request(OP_WRITE, 20'h000F0, 32'h1234_5678);
    send_request(OP_READ,  20'hFFFF0, 32'h0000_0000);
    send_request(OP_READ,  20'h000F0, 32'h0000_0000);
    send_request(OP_READ,  20'hFFFFD, 32'h0000_0000);
    send_request(OP_WRITE, 20'h00C0C, 32'h0000_0000);
    send_request(OP_READ,  20'h00C0C, 32'h0000_0000);
    send_request(OP_WRITE, 20'h7F8A5, 32'h8000_0001);
    send_request(OP_READ,  20'h7F8A3, 32'h0000_0000);
    send_request(OP_WRITE, 20'h80FA9, 32'h5A5A_A5A5);
    send_request(OP_READ,  20'hA5FA9, 32'h0000_0000);
    send_request(OP_READ,  20'h80FA8, 32'h0000_0000);
    drain_responses();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        gaps_on    = $urandom_range(0, 2) != 0;
        rsp_stalls = $urandom_range(0, 2) != 0;
      end
      if (n == RANDOM_ITEMS / 2) drain_responses();
      send_random();
      if (gaps_on && $urandom_range(0, 3) == 0) idle_request(gap_length());
    end

    drain_responses();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
